// ----- rtl/icd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package icd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DistW   = 24;
  localparam int unsigned FarW    = 23;
  localparam int unsigned SpacW   = 16;
  localparam int unsigned DimW    = 11;
  localparam int unsigned ColW    = 10;
  localparam int unsigned RowW    = 10;
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam int unsigned RadW   = 65;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned RootW  = 49;
  localparam int unsigned QuotW  = 64;

  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegFarValue  = 3'd1;
  localparam logic [2:0] RegSpacingX  = 3'd2;
  localparam logic [2:0] RegSpacingY  = 3'd3;
  localparam logic [2:0] RegWidth     = 3'd4;
  localparam logic [2:0] RegHeight    = 3'd5;

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    logic signed [16:0] n;
    n = -v;
    return v[16] ? n[15:0] : v[15:0];
  endfunction

  function automatic logic pos17(logic signed [16:0] v);
    return !v[16] && (v != 17'sd0);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/icd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface icd_in_if;
  import icd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface icd_out_if;
  import icd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DistW-1:0] distance;
  logic [ColW-1:0]         column;
  logic [RowW-1:0]         row;
  logic                    end_of_image;
  modport source (output valid, output distance, output column, output row,
                  output end_of_image, input ready);
  modport sink (input valid, input distance, input column, input row,
                input end_of_image, output ready);
endinterface
`default_nettype wire

// ----- rtl/icd_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icd_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [icd_pkg::RadW-1:0]   rad_i,
  output logic                            done_o,
  output logic [icd_pkg::RootW-1:0]       root_o
);
  import icd_pkg::*;

  localparam int unsigned ExtW = 2 * RootW;

  logic [ExtW-1:0]  rad_q;
  logic [RootW:0]   rem_q;
  logic [RootW-1:0] root_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [RootW+2:0] t;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;
  logic             ge;

  assign t     = {rem_q, rad_q[ExtW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = t - trial;
  assign ge    = (t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= ExtW'({rad_i, {ScaleW{1'b0}}});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[ExtW-3:0], 2'b00};
      rem_q  <= ge ? diff[RootW:0] : t[RootW:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ----- rtl/icd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module icd_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [icd_pkg::QuotW-1:0]  dividend_i,
  input  wire logic [icd_pkg::RootW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [icd_pkg::QuotW-1:0]       quot_o
);
  import icd_pkg::*;

  logic [QuotW-1:0] dq_q;
  logic [RootW-1:0] rem_q;
  logic [RootW-1:0] div_q;
  logic [6:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [RootW:0]   t;
  logic [RootW:0]   diff;
  logic             ge;

  assign t    = {rem_q, dq_q[QuotW-1]};
  assign diff = t - {1'b0, div_q};
  assign ge   = (t >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[QuotW-2:0], ge};
      rem_q <= ge ? diff[RootW-1:0] : t[RootW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

// ----- rtl/isocontour_distance_2d_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed distance initialisation around the threshold iso-contour of a raster-order image.
// Samples enter one beat at a time; results for a row leave while the next row enters, and the
// last row also leaves alongside itself, so each sample beat yields zero, one or two result beats.
// A sample of the first row is written straight into the row stores as it is accepted. Any other
// sample passes through memory access, multiplication, candidate set-up and write-back, plus the
// bit-serial square root, run once, and the one-bit-per-cycle divider, run for each of up to three
// candidate distances where the pixel and a neighbour straddle the threshold; these iterative units
// set the rate when the result side does not stall, and a new sample is taken only once the last
// one is written back. The row stores are not cleared after reset and need no clearing pass.
module isocontour_distance_2d_top #(
  parameter int unsigned MAX_WIDTH  = icd_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = icd_pkg::DefMaxHeight
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  icd_in_if.sink                            in_i,
  icd_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [icd_pkg::PaddrW-1:0]   paddr,
  input  wire logic [icd_pkg::PdataW-1:0]   pwdata,
  output logic [icd_pkg::PdataW-1:0]        prdata,
  output logic                              pready
);
  import icd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [DimW-1:0] WidReset = DimW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
  localparam logic [DimW-1:0] HgtReset = DimW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD0    = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_ROOT   = 4'd6;
  localparam logic [3:0] S_NUM    = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_APPLY  = 4'd10;
  localparam logic [3:0] S_EMIT1  = 4'd11;
  localparam logic [3:0] S_EMIT2  = 4'd12;
  localparam logic [3:0] S_WRR    = 4'd13;
  localparam logic [3:0] S_WRC    = 4'd14;

  localparam logic [1:0] K_ORIGIN = 2'd0;
  localparam logic [1:0] K_RIGHT  = 2'd1;
  localparam logic [1:0] K_DOWN   = 2'd2;

  logic signed [SampleW-1:0] thr_q;
  logic [FarW-1:0]           far_q;
  logic [SpacW-1:0]          sx_q;
  logic [SpacW-1:0]          sy_q;
  logic [DimW-1:0]           wid_q;
  logic [DimW-1:0]           hgt_q;
  logic                      cfg_we;
  logic [DimW-1:0]           wv;
  logic [DimW-1:0]           wid_sat;
  logic [DimW-1:0]           hgt_sat;
  logic [SpacW-1:0]          sp_wr;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign wv     = pwdata[DimW-1:0];
  assign sp_wr  = (pwdata[SpacW-1:0] == '0) ? SpacW'(1) : pwdata[SpacW-1:0];

  always_comb begin
    if (wv < DimW'(2)) begin
      wid_sat = DimW'(2);
    end else if (32'(wv) > MAX_WIDTH) begin
      wid_sat = DimW'(MAX_WIDTH);
    end else begin
      wid_sat = wv;
    end
    if (wv < DimW'(2)) begin
      hgt_sat = DimW'(2);
    end else if (32'(wv) > MAX_HEIGHT) begin
      hgt_sat = DimW'(MAX_HEIGHT);
    end else begin
      hgt_sat = wv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      far_q <= FarW'(2560);
      sx_q  <= SpacW'(256);
      sy_q  <= SpacW'(256);
      wid_q <= WidReset;
      hgt_q <= HgtReset;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        RegThreshold: thr_q <= pwdata[SampleW-1:0];
        RegFarValue:  far_q <= pwdata[FarW-1:0];
        RegSpacingX:  sx_q  <= sp_wr;
        RegSpacingY:  sy_q  <= sp_wr;
        RegWidth:     wid_q <= wid_sat;
        RegHeight:    hgt_q <= hgt_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegThreshold: prdata = PdataW'(thr_q);
      RegFarValue:  prdata = PdataW'(far_q);
      RegSpacingX:  prdata = PdataW'(sx_q);
      RegSpacingY:  prdata = PdataW'(sy_q);
      RegWidth:     prdata = PdataW'(wid_q);
      RegHeight:    prdata = PdataW'(hgt_q);
      default:      prdata = '0;
    endcase
  end

  logic signed [SampleW-1:0] prev_mem [MAX_WIDTH];
  logic signed [DistW-1:0]   pend_mem [MAX_WIDTH];
  logic signed [SampleW-1:0] prev_rd_q;
  logic signed [DistW-1:0]   pend_rd_q;
  logic [CW-1:0]             raddr;
  logic                      prev_we;
  logic [CW-1:0]             prev_waddr;
  logic signed [SampleW-1:0] prev_wdata;
  logic                      pend_we;
  logic [CW-1:0]             pend_waddr;
  logic signed [DistW-1:0]   pend_wdata;

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_q <= prev_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_rd_q <= pend_mem[raddr];
  end

  logic [3:0]                state_q, state_d;
  logic [CW-1:0]             col_q;
  logic [RW-1:0]             row_q;
  logic [CW-1:0]             x_q;
  logic [RW-1:0]             y_q;
  logic                      lastc_q;
  logic                      lastr_q;
  logic signed [SampleW-1:0] s_q;
  logic signed [SampleW-1:0] s0_q;
  logic signed [SampleW-1:0] sr_q;
  logic signed [DistW-1:0]   cur_q;
  logic signed [DistW-1:0]   p0_q;
  logic signed [DistW-1:0]   pr_q;
  logic [31:0]               a_q;
  logic [31:0]               b_q;
  logic [31:0]               sxy_q;
  logic [63:0]               a2_q;
  logic [63:0]               b2_q;
  logic                      cr_q;
  logic                      cd_q;
  logic [1:0]                k_q;
  logic [47:0]               num_q;
  logic                      neg_q;
  logic                      out_valid_q;
  logic signed [DistW-1:0]   out_dist_q;
  logic [ColW-1:0]           out_col_q;
  logic [RowW-1:0]           out_row_q;
  logic                      out_eoi_q;

  logic                      in_acc;
  logic                      last_col;
  logic                      last_row;
  logic signed [DistW-1:0]   cur_d;
  logic signed [16:0]        v0, vr, vd, dra, dda, vk;
  logic                      cr_d, cd_d;
  logic                      root_start, root_done;
  logic [RootW-1:0]          root;
  logic                      div_start, div_done;
  logic [QuotW-1:0]          dividend;
  logic [QuotW-1:0]          quot;
  logic [31:0]               cand;
  logic [32:0]               cand_mag;
  logic signed [DistW-1:0]   held;
  logic [DistW-1:0]          held_mag;
  logic                      smaller;
  logic                      out_free;
  logic                      load1, load2;
  logic [31:0]               row_m1;
  logic [31:0]               col_w;
  logic [31:0]               row_w;

  assign in_acc   = in_i.valid && (state_q == S_IDLE);
  assign last_col = (32'(col_q) + 32'd1) >= 32'(wid_q);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(hgt_q);
  assign cur_d    = (in_i.sample >= thr_q) ? DistW'({1'b0, far_q})
                                          : DistW'(0) - DistW'({1'b0, far_q});

  assign v0  = 17'(s0_q) - 17'(thr_q);
  assign vr  = 17'(sr_q) - 17'(thr_q);
  assign vd  = 17'(s_q) - 17'(thr_q);
  assign dra = 17'(sr_q) - 17'(s0_q);
  assign dda = 17'(s_q) - 17'(s0_q);
  assign cr_d = pos17(v0) != pos17(vr);
  assign cd_d = pos17(v0) != pos17(vd);

  always_comb begin
    unique case (k_q)
      K_ORIGIN: vk = v0;
      K_RIGHT:  vk = vr;
      default:  vk = vd;
    endcase
  end

  always_comb begin
    unique case (k_q)
      K_ORIGIN: held = p0_q;
      K_RIGHT:  held = pr_q;
      default:  held = cur_q;
    endcase
  end

  assign root_start = (state_q == S_SUM) && (cr_d || cd_d);
  assign div_start  = (state_q == S_DSTART);
  assign dividend   = {num_q, 16'b0} + QuotW'(root >> 1);
  assign cand       = neg_q ? (32'd0 - quot[31:0]) : quot[31:0];
  assign cand_mag   = cand[31] ? (33'd0 - {1'b1, cand}) : {1'b0, cand};
  assign held_mag   = held[DistW-1] ? (DistW'(0) - held) : held;
  assign smaller    = cand_mag < 33'(held_mag);

  icd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (RadW'(a2_q) + RadW'(b2_q)),
    .done_o  (root_done),
    .root_o  (root)
  );

  icd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (root),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign load1    = (state_q == S_EMIT1) && out_free;
  assign load2    = (state_q == S_EMIT2) && out_free;
  assign row_m1   = 32'(y_q) - 32'd1;
  assign col_w    = 32'(x_q);
  assign row_w    = 32'(y_q);

  always_comb begin
    raddr      = (state_q == S_IDLE) ? col_q : (x_q + CW'(1));
    prev_we    = 1'b0;
    prev_waddr = x_q;
    prev_wdata = s_q;
    pend_we    = 1'b0;
    pend_waddr = x_q;
    pend_wdata = cur_q;
    priority if (in_acc && (row_q == '0)) begin
      prev_we    = 1'b1;
      prev_waddr = col_q;
      prev_wdata = in_i.sample;
      pend_we    = 1'b1;
      pend_waddr = col_q;
      pend_wdata = cur_d;
    end else if (state_q == S_WRR) begin
      pend_we    = 1'b1;
      pend_waddr = x_q + CW'(1);
      pend_wdata = pr_q;
    end else if (state_q == S_WRC) begin
      prev_we = 1'b1;
      pend_we = 1'b1;
    end else begin
      prev_we = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && (row_q != '0)) state_d = S_RD0;
      S_RD0:    state_d = lastc_q ? S_EMIT1 : S_RD1;
      S_RD1:    state_d = S_MUL1;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_SUM;
      S_SUM:    state_d = (cr_d || cd_d) ? S_ROOT : S_EMIT1;
      S_ROOT:   if (root_done) state_d = S_NUM;
      S_NUM:    state_d = S_DSTART;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (div_done) state_d = S_APPLY;
      S_APPLY: begin
        unique case (k_q)
          K_ORIGIN: state_d = (cr_q || cd_q) ? S_NUM : S_EMIT1;
          K_RIGHT:  state_d = cd_q ? S_NUM : S_EMIT1;
          default:  state_d = S_EMIT1;
        endcase
      end
      S_EMIT1: begin
        if (out_free) begin
          priority if (lastr_q) state_d = S_EMIT2;
          else if (lastc_q)     state_d = S_WRC;
          else                  state_d = S_WRR;
        end
      end
      S_EMIT2:  if (out_free) state_d = lastc_q ? S_WRC : S_WRR;
      S_WRR:    state_d = S_WRC;
      S_WRC:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : (row_q + RW'(1));
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (load1 || load2) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= col_q;
      y_q     <= row_q;
      s_q     <= in_i.sample;
      cur_q   <= cur_d;
      lastc_q <= last_col;
      lastr_q <= last_row;
    end
    if (state_q == S_RD0) begin
      s0_q <= prev_rd_q;
      p0_q <= pend_rd_q;
    end
    if (state_q == S_RD1) begin
      sr_q <= prev_rd_q;
      pr_q <= pend_rd_q;
    end
    if (state_q == S_MUL1) begin
      a_q   <= 32'(mag17(dra)) * 32'(sy_q);
      b_q   <= 32'(mag17(dda)) * 32'(sx_q);
      sxy_q <= 32'(sx_q) * 32'(sy_q);
    end
    if (state_q == S_MUL2) begin
      a2_q <= 64'(a_q) * 64'(a_q);
      b2_q <= 64'(b_q) * 64'(b_q);
    end
    if (state_q == S_SUM) begin
      cr_q <= cr_d;
      cd_q <= cd_d;
      k_q  <= K_ORIGIN;
    end
    if (state_q == S_NUM) begin
      num_q <= 48'(mag17(vk)) * 48'(sxy_q);
      neg_q <= vk[16];
    end
    if (state_q == S_APPLY) begin
      if (smaller) begin
        unique case (k_q)
          K_ORIGIN: p0_q  <= cand[DistW-1:0];
          K_RIGHT:  pr_q  <= cand[DistW-1:0];
          default:  cur_q <= cand[DistW-1:0];
        endcase
      end
      unique case (k_q)
        K_ORIGIN: k_q <= cr_q ? K_RIGHT : K_DOWN;
        default:  k_q <= K_DOWN;
      endcase
    end
    if (load1) begin
      out_dist_q <= p0_q;
      out_col_q  <= col_w[ColW-1:0];
      out_row_q  <= row_m1[RowW-1:0];
      out_eoi_q  <= 1'b0;
    end else if (load2) begin
      out_dist_q <= cur_q;
      out_col_q  <= col_w[ColW-1:0];
      out_row_q  <= row_w[RowW-1:0];
      out_eoi_q  <= lastc_q;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.distance     = out_dist_q;
  assign out_o.column       = out_col_q;
  assign out_o.row          = out_row_q;
  assign out_o.end_of_image = out_eoi_q;

endmodule
`default_nettype wire

// ----- tb/tb_icd_checker.sv -----
`timescale 1ns / 1ps
module tb_icd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  icd_in_if          pix_w,
  icd_out_if         dist_w,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [icd_pkg::PaddrW-1:0] paddr,
  input  logic [icd_pkg::PdataW-1:0] pwdata,
  input  logic       pready,
  output int         errors_o,
  output int         outstanding_o,
  output int         pixels_o,
  output int         beats_o
);
  import icd_pkg::*;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             end_of_image;
  } dist_beat_t;

  int          thr_q;
  int          far_q;
  longint      spx_q;
  longint      spy_q;
  int          wid_q;
  int          hgt_q;
  int          line_samples[1024];
  int          line_dists[1024];
  int          col_cnt;
  int          row_cnt;
  dist_beat_t  due_q[$];

  assign outstanding_o = due_q.size();

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [48:0] grad_root(logic [64:0] n);
    logic [127:0] goal;
    logic [127:0] t;
    logic [127:0] r;
    goal = {31'd0, n, 32'd0};
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= goal) r = t;
    end
    return r[48:0];
  endfunction

  function automatic int near_dist(int v, logic [48:0] root);
    logic [63:0] num;
    logic [63:0] q;
    logic [31:0] c;
    num = 64'(mag(v)) * 64'(spx_q) * 64'(spy_q);
    num = num << 16;
    q = (num + 64'(root >> 1)) / 64'(root);
    c = q[31:0];
    return v < 0 ? -int'(c) : int'(c);
  endfunction

  function automatic void keep_min(ref int held, input int cand);
    if (mag(cand) < mag(held)) held = cand;
  endfunction

  function automatic void push_beat(int d, int c, int r, logic e);
    dist_beat_t b;
    b.distance = d[DistW-1:0];
    b.column = c[ColW-1:0];
    b.row = r[RowW-1:0];
    b.end_of_image = e;
    due_q.push_back(b);
  endfunction

  function automatic void predict_pixel(logic signed [SampleW-1:0] smp);
    int s, x, y, cur, s0, sr, v0, vr, vd;
    logic last_col, last_row, side;
    longint a, b;
    logic [63:0] a2, b2;
    logic [48:0] root;
    s = smp;
    x = col_cnt;
    y = row_cnt;
    if (x >= 1024) x = 1023;
    last_col = (x + 1 >= wid_q);
    last_row = (y + 1 >= hgt_q);
    cur = (s >= thr_q) ? far_q : -far_q;
    if (y > 0) begin
      if (!last_col) begin
        s0 = line_samples[x];
        sr = line_samples[x+1];
        v0 = s0 - thr_q;
        vr = sr - thr_q;
        vd = s - thr_q;
        side = v0 > 0;
        a = mag(sr - s0) * spy_q;
        b = mag(s - s0) * spx_q;
        a2 = 64'(a) * 64'(a);
        b2 = 64'(b) * 64'(b);
        root = grad_root({1'b0, a2} + {1'b0, b2});
        if (side != (vr > 0)) begin
          keep_min(line_dists[x], near_dist(v0, root));
          keep_min(line_dists[x+1], near_dist(vr, root));
        end
        if (side != (vd > 0)) begin
          keep_min(line_dists[x], near_dist(v0, root));
          keep_min(cur, near_dist(vd, root));
        end
      end
      push_beat(line_dists[x], x, y - 1, 1'b0);
      if (last_row) push_beat(cur, x, y, last_col);
    end
    line_samples[x] = s;
    line_dists[x] = cur;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      RegThreshold: thr_q = int'(signed'(v[15:0]));
      RegFarValue:  far_q = int'(v[22:0]);
      RegSpacingX:  spx_q = (v[15:0] == 0) ? 1 : longint'(v[15:0]);
      RegSpacingY:  spy_q = (v[15:0] == 0) ? 1 : longint'(v[15:0]);
      RegWidth:     wid_q = v[10:0] < 2 ? 2 : (v[10:0] > 1024 ? 1024 : int'(v[10:0]));
      RegHeight:    hgt_q = v[10:0] < 2 ? 2 : (v[10:0] > 1024 ? 1024 : int'(v[10:0]));
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dist_beat_t exp_b;
    if (!rst_ni) begin
      thr_q = 0;
      far_q = 2560;
      spx_q = 256;
      spy_q = 256;
      wid_q = 1024;
      hgt_q = 1024;
      col_cnt = 0;
      row_cnt = 0;
      errors_o = 0;
      pixels_o = 0;
      beats_o = 0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(3'(paddr >> 2), pwdata);
      if (dist_w.valid && dist_w.ready) begin
        beats_o++;
        if (due_q.size() == 0) begin
          $error("Unexpected distance beat at column %0d row %0d", dist_w.column, dist_w.row);
          errors_o++;
        end else begin
          exp_b = due_q.pop_front();
          if (dist_w.distance !== exp_b.distance) begin
            $error("distance: expected %0d, actual %0d", $signed(exp_b.distance),
                   $signed(dist_w.distance));
            errors_o++;
          end
          if (dist_w.column !== exp_b.column) begin
            $error("column: expected %0d, actual %0d", exp_b.column, dist_w.column);
            errors_o++;
          end
          if (dist_w.row !== exp_b.row) begin
            $error("row: expected %0d, actual %0d", exp_b.row, dist_w.row);
            errors_o++;
          end
          if (dist_w.end_of_image !== exp_b.end_of_image) begin
            $error("end_of_image: expected %0b, actual %0b", exp_b.end_of_image,
                   dist_w.end_of_image);
            errors_o++;
          end
        end
      end
      if (pix_w.valid && pix_w.ready) begin
        pixels_o++;
        predict_pixel(pix_w.sample);
      end
    end
  end
endmodule

// ----- tb/tb_isocontour_distance_2d_top.sv -----
`timescale 1ns / 1ps
module tb_isocontour_distance_2d_top;
  import icd_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  int                errors;
  int                outstanding;
  int                pixels;
  int                beats;
  int                images;
  int                quiet_cycles;
  bit                no_gaps;
  bit                no_stalls;
  int                thr;
  int                wid;
  int                hgt;

  icd_in_if  pix_w ();
  icd_out_if dist_w ();

  isocontour_distance_2d_top dut (
    .clk_i, .rst_ni, .in_i(pix_w), .out_o(dist_w),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tb_icd_checker checker_u (
    .clk_i, .rst_ni, .pix_w, .dist_w, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .errors_o(errors), .outstanding_o(outstanding), .pixels_o(pixels),
    .beats_o(beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((pix_w.valid && pix_w.ready) || (dist_w.valid && dist_w.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    stall = 0;
    dist_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (dist_w.valid && dist_w.ready) begin
        stall = no_stalls ? 0 : $urandom_range(0, 19);
        if (stall > 0) dist_w.ready <= 1'b0;
      end else if (!dist_w.ready) begin
        if (stall <= 1) dist_w.ready <= 1'b1;
        stall--;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PaddrW'(idx) << 2;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(int s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      pix_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_w.valid <= 1'b1;
    pix_w.sample <= SampleW'(s);
    @(posedge clk_i);
    while (!pix_w.ready) @(posedge clk_i);
  endtask

  task automatic settle();
    @(posedge clk_i);
    pix_w.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic int clamp16(int v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  task automatic configure(int t, int f, int sx, int sy, int w, int h);
    apb_write(RegThreshold, 32'(t));
    apb_write(RegFarValue, 32'(f));
    apb_write(RegSpacingX, 32'(sx));
    apb_write(RegSpacingY, 32'(sy));
    apb_write(RegWidth, 32'(w));
    apb_write(RegHeight, 32'(h));
    thr = t;
    wid = w < 2 ? 2 : (w > 1024 ? 1024 : w);
    hgt = h < 2 ? 2 : (h > 1024 ? 1024 : h);
  endtask

  task automatic send_image(int style);
    for (int i = 0; i < wid * hgt; i++) begin
      case (style)
        0: send_pixel(clamp16(thr + $urandom_range(0, 40) - 20));
        1: send_pixel(int'(signed'(16'($urandom()))));
        default: send_pixel(($urandom_range(0, 1) != 0) ? 32767 : -32768);
      endcase
    end
    images++;
  endtask

  initial begin
    int extremes[8];
    extremes = '{-32768, 32767, 0, -1, 1, 32767, -32768, 0};
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_w.valid <= 1'b0;
    pix_w.sample <= '0;
    images = 0;
    no_gaps = 0;
    no_stalls = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(0, 2560, 256, 256, 4, 3);
    for (int i = 0; i < 12; i++) send_pixel(extremes[i % 8]);
    images++;
    settle();
    configure(-32768, 8388607, 1, 65535, 3, 2);
    send_image(1);
    settle();
    configure(32767, 0, 65535, 1, 0, 1);
    send_image(2);
    settle();
    configure(5, 100, 0, 0, 2, 3);
    send_image(0);
    settle();
    configure(-20, 2560, 300, 200, 12, 2);
    send_image(1);
    settle();

    while (pixels < 800) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      no_stalls = ($urandom_range(0, 3) == 0);
      configure(($urandom_range(0, 3) == 0) ? int'(signed'(16'($urandom())))
                                            : $urandom_range(0, 200) - 100,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 8388607)
                                          : $urandom_range(0, 5000),
                $urandom_range(0, 2) == 0 ? $urandom_range(1, 65535) : $urandom_range(64, 1024),
                $urandom_range(0, 2) == 0 ? $urandom_range(1, 65535) : $urandom_range(64, 1024),
                $urandom_range(2, 12), $urandom_range(2, 6));
      send_image($urandom_range(0, 4) < 3 ? 0 : ($urandom_range(0, 5) == 0 ? 2 : 1));
      settle();
    end

    $display("Streamed %0d samples over %0d images and checked %0d distance beats.",
             pixels, images, beats);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/icd_pkg.sv
rtl/icd_if.sv
rtl/icd_sqrt.sv
rtl/icd_div.sv
rtl/isocontour_distance_2d_top.sv
tb/tb_icd_checker.sv
tb/tb_isocontour_distance_2d_top.sv
